### src/dual_pi_led_current_regulator_top_defines.svh
// Assertion helpers used by the top-level RTL file.
`ifndef DUAL_PI_LED_CURRENT_REGULATOR_TOP_DEFINES_SVH
`define DUAL_PI_LED_CURRENT_REGULATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DPLCR_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define DPLCR_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

### src/dplcr_pkg.sv
package dplcr_pkg;

  localparam int CurrentWidth = 12;
  localparam int ErrWidth     = CurrentWidth + 1;
  localparam int DutyWidth    = 8;
  localparam int IntegShift   = 10;
  localparam int IntegWidth   = DutyWidth + IntegShift;
  localparam int SumWidth     = IntegWidth + 2;
  localparam int RawWidth     = SumWidth - DutyWidth;
  localparam int CfgIdxWidth  = 1;

  localparam logic [DutyWidth-1:0] MaxDutyReset   = 8'd254;
  localparam logic [DutyWidth-1:0] MinSumDutyReset = 8'd25;

  localparam logic [CfgIdxWidth-1:0] RegMaxDuty    = 1'b0;
  localparam logic [CfgIdxWidth-1:0] RegMinSumDuty = 1'b1;

  typedef enum logic {
    CMD_REGULATE = 1'b0,
    CMD_RESET    = 1'b1
  } command_t;

  typedef enum logic {
    CH_LEFT  = 1'b0,
    CH_RIGHT = 1'b1
  } channel_t;

  typedef enum logic [1:0] {
    STATUS_OK  = 2'd0,
    STATUS_MIN = 2'd1,
    STATUS_MAX = 2'd2
  } status_t;

  typedef struct packed {
    command_t                command;
    channel_t                channel;
    logic [CurrentWidth-1:0] target_current;
    logic [CurrentWidth-1:0] measured_current;
  } req_t;

  typedef struct packed {
    logic [DutyWidth-1:0] duty_left;
    logic [DutyWidth-1:0] duty_right;
    status_t              status;
  } rsp_t;

  typedef struct packed {
    logic [IntegWidth-1:0] integ;
    logic [DutyWidth-1:0]  duty;
    status_t               status;
  } pi_result_t;

endpackage

### src/dplcr_pi.sv
module dplcr_pi import dplcr_pkg::*; (
  input  logic [IntegWidth-1:0]   integ,
  input  logic [DutyWidth-1:0]    other_duty,
  input  logic [CurrentWidth-1:0] target_current,
  input  logic [CurrentWidth-1:0] measured_current,
  input  logic [DutyWidth-1:0]    max_duty,
  input  logic [DutyWidth-1:0]    min_sum_duty,
  output pi_result_t              result
);

  logic signed [ErrWidth-1:0] err;
  logic signed [SumWidth-1:0] err_ext;
  logic signed [SumWidth-1:0] integ_sum;
  logic [IntegWidth-1:0]      limit;
  logic [IntegWidth-1:0]      integ_new;
  logic signed [SumWidth-1:0] pre_duty;
  logic signed [RawWidth-1:0] raw;
  logic signed [RawWidth-1:0] max_ext;
  logic signed [RawWidth-1:0] lower_ext;
  logic [DutyWidth-1:0]       lower;

  assign err = $signed({1'b0, target_current}) - $signed({1'b0, measured_current});
  assign err_ext = {{(SumWidth-ErrWidth){err[ErrWidth-1]}}, err};
  assign integ_sum = $signed({2'b00, integ}) + err_ext;
  assign limit = {max_duty, {IntegShift{1'b0}}};

  // Clamp integrator to 0 .. max_duty<<10.
  always_comb begin
    priority if (integ_sum[SumWidth-1]) begin
      integ_new = '0;
    end else if (integ_sum[SumWidth-2:0] > {1'b0, limit}) begin
      integ_new = limit;
    end else begin
      integ_new = integ_sum[IntegWidth-1:0];
    end
  end

  assign pre_duty = $signed({4'b0000, integ_new[IntegWidth-1:2]}) + err_ext;
  // Arithmetic shift by 8 rounds toward minus infinity.
  assign raw = pre_duty[SumWidth-1:DutyWidth];
  assign max_ext = $signed({{(RawWidth-DutyWidth){1'b0}}, max_duty});
  assign lower = (other_duty < min_sum_duty) ? (min_sum_duty - other_duty) : '0;
  assign lower_ext = $signed({{(RawWidth-DutyWidth){1'b0}}, lower});

  always_comb begin
    result.integ = integ_new;
    priority if (target_current == '0) begin
      result.integ  = '0;
      result.duty   = '0;
      result.status = STATUS_OK;
    end else if (raw > max_ext) begin
      result.duty   = max_duty;
      result.status = STATUS_MAX;
    end else if (raw < lower_ext) begin
      result.duty   = lower;
      result.status = STATUS_MIN;
    end else begin
      result.duty   = raw[DutyWidth-1:0];
      result.status = STATUS_OK;
    end
  end

endmodule

### src/dual_pi_led_current_regulator_top.sv
// Two-channel PI current regulator for buck LED drivers.
// Request channel (req_valid/req_stall/req): one item either regulates one
// channel from a target and a measured current, or resets both channels.
// Response channel (rsp_valid/rsp_stall/rsp): one item per request, with both
// duties after the update and a status (ok, clamped at min, clamped at max).
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 sets the
// max duty, index 1 the least combined duty; always ready. Write it only
// while no request is in flight.
// Flow: a request is held in the input register, then passes through the
// PI update into the response register. Throughput: one item per cycle
// while the response is not stalled; the integrator and duty registers
// are written by the same edge that loads the response register, so the
// next item sees them without waiting.
// Reset (rst, synchronous): integrators and duties to zero, max duty 254,
// least combined duty 25, both pipeline stages empty.
// A valid response holds under rsp_stall; the input register holds behind
// it and req_stall rises only when that register is occupied.
module dual_pi_led_current_regulator_top import dplcr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  req_t                   req,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output rsp_t                   rsp,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [DutyWidth-1:0]   cfg_data
);

`include "dual_pi_led_current_regulator_top_defines.svh"

  logic                  stage_valid;
  req_t                  stage;
  logic                  advance;
  logic [DutyWidth-1:0]  max_duty;
  logic [DutyWidth-1:0]  min_sum_duty;
  logic [IntegWidth-1:0] integ_left;
  logic [IntegWidth-1:0] integ_right;
  logic [DutyWidth-1:0]  duty_left;
  logic [DutyWidth-1:0]  duty_right;
  logic [IntegWidth-1:0] integ_left_next;
  logic [IntegWidth-1:0] integ_right_next;
  logic [DutyWidth-1:0]  duty_left_next;
  logic [DutyWidth-1:0]  duty_right_next;
  status_t               status_next;
  logic [IntegWidth-1:0] sel_integ;
  logic [DutyWidth-1:0]  sel_other;
  pi_result_t            pi_res;

  assign cfg_ready = 1'b1;
  assign advance   = stage_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_duty     <= MaxDutyReset;
      min_sum_duty <= MinSumDutyReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegMaxDuty:    max_duty     <= cfg_data;
        RegMinSumDuty: min_sum_duty <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!req_stall) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      stage <= req;
    end
  end

  assign sel_integ = (stage.channel == CH_LEFT) ? integ_left : integ_right;
  assign sel_other = (stage.channel == CH_LEFT) ? duty_right : duty_left;

  dplcr_pi u_pi (
    .integ            (sel_integ),
    .other_duty       (sel_other),
    .target_current   (stage.target_current),
    .measured_current (stage.measured_current),
    .max_duty         (max_duty),
    .min_sum_duty     (min_sum_duty),
    .result           (pi_res)
  );

  always_comb begin
    integ_left_next  = integ_left;
    integ_right_next = integ_right;
    duty_left_next   = duty_left;
    duty_right_next  = duty_right;
    status_next      = STATUS_OK;
    unique case (stage.command)
      CMD_RESET: begin
        integ_left_next  = '0;
        integ_right_next = '0;
        duty_left_next   = '0;
        duty_right_next  = '0;
      end
      CMD_REGULATE: begin
        status_next = pi_res.status;
        unique case (stage.channel)
          CH_LEFT: begin
            integ_left_next = pi_res.integ;
            duty_left_next  = pi_res.duty;
          end
          CH_RIGHT: begin
            integ_right_next = pi_res.integ;
            duty_right_next  = pi_res.duty;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_left  <= '0;
      integ_right <= '0;
      duty_left   <= '0;
      duty_right  <= '0;
    end else if (advance) begin
      integ_left  <= integ_left_next;
      integ_right <= integ_right_next;
      duty_left   <= duty_left_next;
      duty_right  <= duty_right_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.duty_left  <= duty_left_next;
      rsp.duty_right <= duty_right_next;
      rsp.status     <= status_next;
    end
  end

  `DPLCR_ASSERT_NOW(a_empty_never_stalls, clk, rst, !stage_valid, !req_stall)
  `DPLCR_ASSERT_NEXT(a_reset_clears, clk, rst, advance && stage.command == CMD_RESET,
    integ_left == '0 && integ_right == '0 && duty_left == '0 && duty_right == '0)
  `DPLCR_ASSERT_NEXT(a_left_integ_limit, clk, rst,
    advance && stage.command == CMD_REGULATE && stage.channel == CH_LEFT,
    integ_left <= (IntegWidth'(max_duty) << IntegShift))
  `DPLCR_ASSERT_NEXT(a_off_is_ok, clk, rst,
    advance && stage.command == CMD_REGULATE && stage.target_current == '0,
    rsp_valid && rsp.status == STATUS_OK)

endmodule

### verif/dplcr_tb_pkg.sv
package dplcr_tb_pkg;
  import dplcr_pkg::*;

  class duty_scoreboard;
    int max_duty;
    int min_sum_duty;
    int integral[2];
    int duty[2];
    rsp_t expected_duties[$];
    int errors;
    int requests;
    int responses;
    int reg_writes;
    int status_seen[3];

    function new();
      max_duty = int'(MaxDutyReset);
      min_sum_duty = int'(MinSumDutyReset);
      integral = '{0, 0};
      duty = '{0, 0};
      errors = 0;
      requests = 0;
      responses = 0;
      reg_writes = 0;
      status_seen = '{0, 0, 0};
    endfunction

    function void set_register(logic [CfgIdxWidth-1:0] idx, logic [DutyWidth-1:0] data);
      if (idx == RegMaxDuty) begin
        max_duty = int'(data);
      end else begin
        min_sum_duty = int'(data);
      end
      reg_writes++;
    endfunction

    // PI update of one channel; the other channel's duty sets the lower bound.
    function status_t update_duty(int ch, int target, int measured);
      int err;
      int limit;
      int acc;
      int raw;
      int lower;
      if (target == 0) begin
        duty[ch] = 0;
        integral[ch] = 0;
        return STATUS_OK;
      end
      err = target - measured;
      limit = max_duty << IntegShift;
      acc = integral[ch] + err;
      if (acc > limit) begin
        acc = limit;
      end else if (acc < 0) begin
        acc = 0;
      end
      integral[ch] = acc;
      // arithmetic shift floors a negative sum
      raw = ((acc >>> 2) + err) >>> DutyWidth;
      lower = (duty[1-ch] < min_sum_duty) ? min_sum_duty - duty[1-ch] : 0;
      if (raw > max_duty) begin
        duty[ch] = max_duty;
        return STATUS_MAX;
      end
      if (raw < lower) begin
        duty[ch] = lower;
        return STATUS_MIN;
      end
      duty[ch] = raw;
      return STATUS_OK;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      status_t st;
      requests++;
      if (r.command == CMD_RESET) begin
        integral = '{0, 0};
        duty = '{0, 0};
        st = STATUS_OK;
      end else begin
        st = update_duty((r.channel == CH_RIGHT) ? 1 : 0, int'(r.target_current),
                         int'(r.measured_current));
      end
      e.duty_left = 8'(duty[0]);
      e.duty_right = 8'(duty[1]);
      e.status = st;
      expected_duties.push_back(e);
    endfunction

    function int pending();
      return expected_duties.size();
    endfunction

    task report_mismatch(string what);
      if (errors < 50) begin
        $display("mismatch at %0t: %s", $realtime, what);
      end
      errors++;
    endtask

    task check_response(rsp_t got);
      rsp_t e;
      responses++;
      if (expected_duties.size() == 0) begin
        report_mismatch($sformatf("response %0d with no request outstanding", responses));
        return;
      end
      e = expected_duties.pop_front();
      status_seen[int'(e.status)]++;
      if (got.duty_left !== e.duty_left) begin
        report_mismatch($sformatf("response %0d duty_left %0d, expected %0d",
                                  responses, got.duty_left, e.duty_left));
      end
      if (got.duty_right !== e.duty_right) begin
        report_mismatch($sformatf("response %0d duty_right %0d, expected %0d",
                                  responses, got.duty_right, e.duty_right));
      end
      if (got.status !== e.status) begin
        report_mismatch($sformatf("response %0d status %0d, expected %0d",
                                  responses, got.status, e.status));
      end
    endtask
  endclass

endpackage

### verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dplcr_pkg::*;
  import dplcr_tb_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int HoldCycles = 150;
  localparam int NumPhases = 10;
  localparam int ItemsPerPhase = 106;
  localparam int PressureItems = 40;

  bit clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index;
  logic [DutyWidth-1:0] cfg_data;

  duty_scoreboard sb;
  int hold_token = 0;

  dual_pi_led_current_regulator_top dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Response side: stall pattern changes mode now and then; a new hold token
  // starts a long hold-off.
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int hold_seen = 0;
  int stall_phase = 0;

  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HoldCycles;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    stall_phase++;
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 3) == 0);
        2: rsp_stall <= ($urandom_range(0, 3) != 0);
        default: rsp_stall <= ((stall_phase % 5) < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      sb.check_response(rsp);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("no progress for %0d cycles", IdleLimit);
    $display("FAILURE");
    $finish;
  end

  function automatic req_t make_req(command_t cmd, channel_t ch, logic [CurrentWidth-1:0] t,
                                    logic [CurrentWidth-1:0] m);
    req_t r;
    r.command = cmd;
    r.channel = ch;
    r.target_current = t;
    r.measured_current = m;
    return r;
  endfunction

  // Mostly closed loop: the measured current follows the channel's duty.
  function automatic req_t next_item();
    req_t r;
    int ch;
    int pick;
    int level;
    ch = $urandom_range(0, 1);
    pick = $urandom_range(0, 99);
    r.command = CMD_REGULATE;
    r.channel = channel_t'(ch);
    r.target_current = 12'($urandom);
    r.measured_current = 12'($urandom);
    if (pick < 4) begin
      r.command = CMD_RESET;
    end else if (pick < 12) begin
      r.target_current = '0;
    end else if (pick < 16) begin
      r.target_current = '1;
      r.measured_current = '0;
    end else if (pick < 20) begin
      r.target_current = 12'd1;
      r.measured_current = '1;
    end else if (pick >= 32) begin
      level = sb.duty[ch] * 16 + int'($urandom_range(0, 64)) - 32;
      if (level < 0) begin
        level = 0;
      end else if (level > 4095) begin
        level = 4095;
      end
      r.measured_current = 12'(level);
      if (r.target_current == 0) begin
        r.target_current = 12'd1;
      end
    end
    return r;
  endfunction

  task send_item(req_t item);
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) begin
      @(posedge clk);
    end
    sb.note_request(item);
    @(negedge clk);
  endtask

  task idle_cycles(int k);
    if (k > 0) begin
      req_valid <= 1'b0;
      repeat (k) @(negedge clk);
    end
  endtask

  task wait_idle();
    req_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) begin
      @(negedge clk);
    end
  endtask

  task write_register(logic [CfgIdxWidth-1:0] idx, logic [DutyWidth-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    sb.set_register(idx, data);
    @(negedge clk);
  endtask

  task configure(int max_duty, int min_sum_duty);
    write_register(RegMaxDuty, 8'(max_duty));
    write_register(RegMinSumDuty, 8'(min_sum_duty));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task run_random(int n, int phase);
    int sent;
    int burst;
    int gap_max;
    sent = 0;
    if (phase == 1 || phase == 6) begin
      // stall the response side for a long stretch and keep offering items
      hold_token <= hold_token + 1;
      repeat (PressureItems) send_item(next_item());
    end
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      for (int i = 0; i < burst && sent < n; i++) begin
        send_item(next_item());
        sent++;
        if (phase == 4 && sent == n / 2) begin
          wait_idle();
        end
      end
      idle_cycles((gap_max > 0) ? $urandom_range(0, gap_max) : 0);
    end
  endtask

  initial begin
    req_t directed[$];
    int max_set[NumPhases] = '{254, 254, 10, 1, 254, 1, 128, 0, 0, 0};
    int min_set[NumPhases] = '{25, 0, 25, 254, 254, 0, 100, 0, 0, 0};
    sb = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int p = 7; p < NumPhases; p++) begin
      max_set[p] = $urandom_range(1, 254);
      min_set[p] = $urandom_range(0, 254);
    end

    directed.push_back(make_req(CMD_RESET, CH_RIGHT, '1, '1));
    directed.push_back(make_req(CMD_REGULATE, CH_LEFT, '1, '0));
    directed.push_back(make_req(CMD_REGULATE, CH_LEFT, '1, '0));
    directed.push_back(make_req(CMD_REGULATE, CH_RIGHT, '1, '0));
    directed.push_back(make_req(CMD_REGULATE, CH_LEFT, 12'd1, '1));
    directed.push_back(make_req(CMD_REGULATE, CH_RIGHT, '0, '1));
    directed.push_back(make_req(CMD_REGULATE, CH_LEFT, 12'd100, 12'd100));
    directed.push_back(make_req(CMD_REGULATE, CH_RIGHT, 12'd2048, 12'd2047));
    directed.push_back(make_req(CMD_RESET, CH_LEFT, '0, '0));
    directed.push_back(make_req(CMD_REGULATE, CH_LEFT, 12'd10, '0));
    directed.push_back(make_req(CMD_REGULATE, CH_RIGHT, '1, '1));
    directed.push_back(make_req(CMD_REGULATE, CH_LEFT, '0, '0));
    directed.push_back(make_req(CMD_REGULATE, CH_RIGHT, 12'd1, '0));
    directed.push_back(make_req(CMD_REGULATE, CH_RIGHT, 12'h555, 12'hAAA));
    directed.push_back(make_req(CMD_REGULATE, CH_LEFT, 12'hAAA, 12'h555));
    directed.push_back(make_req(CMD_RESET, CH_RIGHT, 12'h123, 12'h456));
    directed.push_back(make_req(CMD_REGULATE, CH_RIGHT, '1, '0));

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      send_item(directed[i]);
      idle_cycles(i % 3);
    end
    wait_idle();

    for (int p = 0; p < NumPhases; p++) begin
      configure(max_set[p], min_set[p]);
      run_random(ItemsPerPhase, p);
      wait_idle();
    end

    repeat (4) @(posedge clk);
    $display("run covered %0d requests and %0d responses over %0d register writes",
             sb.requests, sb.responses, sb.reg_writes);
    $display("statuses seen: ok %0d, min clamp %0d, max clamp %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
